// File: design/segment_tree_range_sum_defines.svh
// Assertion macros shared by the segment tree range sum design.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef SEGMENT_TREE_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/strs_pkg.sv
// Package for the segment tree range sum block: widths, codes and state type.
// No dependencies; used by strs_ram and segment_tree_range_sum.
`timescale 1ns / 1ps
`default_nettype none
package strs_pkg;

  localparam int LEAVES_DEFAULT = 1024;
  localparam int IDX_W          = 10;
  localparam int DATA_W         = 64;

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_Q_LEFT,
    ST_Q_RIGHT
  } state_t;

endpackage
`default_nettype wire

// File: design/strs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on strs_pkg for its default width.
`timescale 1ns / 1ps
`default_nettype none
module strs_ram
  import strs_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = 2 * LEAVES_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/segment_tree_range_sum.sv
// Segment tree range sum. A set reads the leaf, then updates one node per cycle on the
// leaf-to-root path, limited by the single read port of the node RAM.
// A query walks L levels from the leaves upward, a Q_LEFT and a Q_RIGHT state per level
// (at most ceil(log2(2*LEAVES)) levels, 11 at 1024 leaves), and then strobes done; an empty
// range walks no levels.
// After reset the block clears all 2*LEAVES nodes, one per cycle, with busy high.
// The result is shown on sum for the one cycle that done is high and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_tree_range_sum_defines.svh"
module segment_tree_range_sum
  import strs_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              func,
  input  wire logic [IDX_W-1:0]  index_a,
  input  wire logic [IDX_W-1:0]  index_b,
  input  wire logic [DATA_W-1:0] value,
  output logic                   done,
  output logic [DATA_W-1:0]      sum
);

  // Node slots: leaves sit at LEAVES .. 2*LEAVES-1, node 1 is the root, slot 0 unused.
  localparam int DEPTH = 2 * LEAVES;
  localparam int NW    = $clog2(DEPTH);
  // The query bounds run up to 2*LEAVES, so they need one bit more than an address.
  localparam int RW    = NW + 1;
  // Width for comparing the element indices against LEAVES without overflow.
  localparam int CW    = ((NW > IDX_W) ? NW : IDX_W) + 1;

  state_t state, state_next;

  logic [NW-1:0]     clr;
  logic [NW-1:0]     k, k_next;
  logic [RW-1:0]     l, l_next;
  logic [RW-1:0]     r, r_next;
  logic [DATA_W-1:0] delta, delta_next;
  logic [DATA_W-1:0] val_reg;
  logic [DATA_W-1:0] acc, acc_next, acc_pl;
  logic              pend, pend_next;
  logic              done_next;
  logic [DATA_W-1:0] sum_next;

  logic              we;
  logic [NW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [NW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  logic [CW-1:0]     a_ext, b_ext, b_cl, leaves_c;
  logic              q_empty;
  logic              is_leaf;
  logic [NW-1:0]     k_up;
  logic              q_walk;
  logic              q_accept;

  strs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Index checks: the upper bound of a query is clamped to the last element, and a
  // first index past the end or above the upper bound gives an empty range.
  assign leaves_c = CW'(LEAVES);
  assign a_ext    = CW'(index_a);
  assign b_ext    = CW'(index_b);
  assign b_cl     = (b_ext >= leaves_c) ? (leaves_c - CW'(1)) : b_ext;
  assign q_empty  = (a_ext >= leaves_c) || (a_ext > b_cl);

  // The only node on a set's path at or above LEAVES is the leaf itself.
  assign is_leaf  = (k >= NW'(LEAVES));
  assign k_up     = k >> 1;

  // A node read during a query lands in the next cycle and is folded in then.
  assign acc_pl   = acc + (pend ? rdata : '0);

  assign busy     = (state != ST_IDLE);

  // Status terms used by the checks below.
  assign q_walk   = (state == ST_Q_LEFT) || (state == ST_Q_RIGHT);
  assign q_accept = (state == ST_IDLE) && start && (func == FUNC_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      done  <= done_next;
      if (state == ST_CLEAR) begin
        clr <= clr + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    l     <= l_next;
    r     <= r_next;
    delta <= delta_next;
    acc   <= acc_next;
    sum   <= sum_next;
    if (start && !busy) begin
      val_reg <= value;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    l_next     = l;
    r_next     = r;
    delta_next = delta;
    acc_next   = acc;
    pend_next  = 1'b0;
    done_next  = 1'b0;
    sum_next   = sum;
    we         = 1'b0;
    waddr      = k;
    wdata      = rdata + delta;
    raddr      = k;

    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
        if (clr == NW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_SET) begin
            // A set beyond the last element is dropped.
            if (a_ext < leaves_c) begin
              k_next     = NW'(a_ext + leaves_c);
              state_next = ST_SET_RD;
            end
          end else begin
            // An empty range walks no levels and returns zero.
            l_next     = q_empty ? '0 : RW'(a_ext + leaves_c);
            r_next     = q_empty ? '0 : RW'(b_cl + leaves_c + CW'(1));
            acc_next   = '0;
            state_next = ST_Q_LEFT;
          end
        end
      end

      ST_SET_RD: begin
        raddr      = k;
        state_next = ST_SET_WR;
      end

      ST_SET_WR: begin
        // The leaf takes the new value and fixes the difference for every ancestor.
        // The parent read goes out in the same cycle, so one node is done per cycle.
        we     = 1'b1;
        waddr  = k;
        raddr  = k_up;
        k_next = k_up;
        if (is_leaf) begin
          wdata      = val_reg;
          delta_next = val_reg - rdata;
        end
        if (k_up == '0) begin
          state_next = ST_IDLE;
        end
      end

      ST_Q_LEFT: begin
        acc_next = acc_pl;
        if (l < r) begin
          if (l[0]) begin
            raddr     = NW'(l);
            pend_next = 1'b1;
            l_next    = l + RW'(1);
          end
          state_next = ST_Q_RIGHT;
        end else begin
          done_next  = 1'b1;
          sum_next   = acc_pl;
          state_next = ST_IDLE;
        end
      end

      ST_Q_RIGHT: begin
        acc_next = acc_pl;
        if (r[0]) begin
          raddr     = NW'(r - RW'(1));
          pend_next = 1'b1;
        end
        // For an odd bound, (r - 1) >> 1 equals r >> 1.
        l_next     = l >> 1;
        r_next     = r >> 1;
        state_next = ST_Q_LEFT;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `STRS_ASSERT_NOW(a_done_from_walk, done, $past(state) == ST_Q_LEFT, "stray result strobe")
  `STRS_ASSERT_NEXT(a_done_single, done, !done, "result strobe held over a cycle")
  `STRS_ASSERT_NOW(a_no_write_query, q_walk, !we, "node write during a query")
  `STRS_ASSERT_NEXT(a_query_starts, q_accept, (state == ST_Q_LEFT) && busy, "walk not started")

endmodule
`default_nettype wire
